FILE: sv/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and codes for the command-driven task scheduler.
// ----------------------------------------------------------------------------
package tsm_pkg;

    typedef enum logic [3:0] {
        OP_CREATE     = 4'd0,
        OP_READY      = 4'd1,
        OP_POP        = 4'd2,
        OP_TERMINATE  = 4'd3,
        OP_SLEEP      = 4'd4,
        OP_ROUSE      = 4'd5,
        OP_MON_CREATE = 4'd6,
        OP_ENTER      = 4'd7,
        OP_EXIT       = 4'd8,
        OP_WAIT       = 4'd9,
        OP_NOTIFY     = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_ARG     = 3'd2,
        ST_STATE   = 3'd3,
        ST_NOSLOT  = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUT_INIT,
        S_WALK,
        S_LINK,
        S_TAKE,
        S_ROUSE,
        S_DONE
    } state_t;

    // what follows an ordered insert
    typedef enum logic [1:0] {
        POST_DONE,
        POST_HAND,
        POST_ROUSE
    } post_t;

    // what a head removal serves
    typedef enum logic [1:0] {
        TK_POP,
        TK_HAND,
        TK_NOTIFY
    } take_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  pid;
        logic [1:0]  mon_id;
        logic [7:0]  priority_req;
        logic [63:0] time_value;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] pid_out;
        logic [1:0] mon_out;
        logic [3:0] moved_count;
    } result_t;

endpackage

FILE: sv/tsm_cmp.sv
// ----------------------------------------------------------------------------
// tsm_cmp
// Shared 64-bit unsigned less-than unit for queue ordering and wake checks.
// ----------------------------------------------------------------------------
module tsm_cmp (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        lt
);
    assign lt = (a < b);
endmodule

FILE: sv/tsm_engine.sv
// ----------------------------------------------------------------------------
// tsm_engine
// Process table, linked queues and monitors under a small sequencer.
// ----------------------------------------------------------------------------
module tsm_engine #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_MONITORS  = 4,
    parameter int PRIORITY_BITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  tsm_pkg::cmd_t    cmd,
    output logic             idle,
    output logic             res_valid,
    input  logic             res_take,
    output tsm_pkg::result_t res
);
    import tsm_pkg::*;

    localparam int IW = $clog2(NUM_PROCESSES + 1);
    localparam int PW = $clog2(NUM_PROCESSES);
    localparam int MW = (NUM_MONITORS > 1) ? $clog2(NUM_MONITORS) : 1;
    localparam int NQ = 2 + 2 * NUM_MONITORS;
    localparam int QW = $clog2(NQ);
    localparam logic [IW-1:0] NIL = IW'(NUM_PROCESSES);
    localparam logic [QW-1:0] QREADY = QW'(0);
    localparam logic [QW-1:0] QSLEEP = QW'(1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    logic [NUM_PROCESSES-1:0] in_use_reg, in_use_next;
    logic [NUM_PROCESSES-1:0] queued_reg, queued_next;
    logic [PRIORITY_BITS-1:0] prio_reg [NUM_PROCESSES];
    logic [PRIORITY_BITS-1:0] prio_next [NUM_PROCESSES];
    logic [63:0]              wake_reg [NUM_PROCESSES];
    logic [63:0]              wake_next [NUM_PROCESSES];
    logic [IW-1:0]            link_reg [NUM_PROCESSES];
    logic [IW-1:0]            link_next [NUM_PROCESSES];
    logic [IW-1:0]            head_reg [NQ];
    logic [IW-1:0]            head_next [NQ];
    logic [NUM_MONITORS-1:0]  mon_use_reg, mon_use_next;
    logic [NUM_MONITORS-1:0]  mon_busy_reg, mon_busy_next;
    logic [IW-1:0]            owner_reg [NUM_MONITORS];
    logic [IW-1:0]            owner_next [NUM_MONITORS];

    logic [QW-1:0] q_reg, q_next, take_q_reg, take_q_next;
    logic [IW-1:0] node_reg, node_next, t_reg, t_next, after_reg, after_next;
    logic [IW-1:0] guard_reg, guard_next, moved_reg, moved_next;
    logic [63:0]   key_reg, key_next;
    logic          by_wake_reg, by_wake_next;
    post_t         post_reg, post_next;
    take_t         tk_reg, tk_next;
    status_t       status_reg, status_next;
    logic [PW-1:0] pid_out_reg, pid_out_next;
    logic [MW-1:0] mon_out_reg, mon_out_next;

    // decode of the held command
    logic [PW-1:0] pidx;
    logic [MW-1:0] midx;
    logic [IW-1:0] pid_ext;
    logic [QW-1:0] qe, qc;
    logic          p_ok, m_ok;
    status_t       link_st;
    logic          free_found, mfree_found;
    logic [PW-1:0] free_idx;
    logic [MW-1:0] mfree_idx;
    state_t        exec_state;
    status_t       exec_status;

    logic [IW-1:0]            rd_idx;
    logic [PRIORITY_BITS-1:0] prio_rd;
    logic [63:0]              wake_rd;
    logic [63:0]              cmp_a, cmp_b;
    logic                     cmp_lt;
    logic [IW-1:0]            sleep_h, take_h;
    logic                     walk_stop, rouse_go;

    assign pidx    = PW'(cmd_reg.pid);
    assign midx    = MW'(cmd_reg.mon_id);
    assign pid_ext = IW'(cmd_reg.pid);
    assign qe      = QW'(2 + int'(midx));
    assign qc      = QW'(2 + NUM_MONITORS + int'(midx));
    assign p_ok    = (32'(cmd_reg.pid) < NUM_PROCESSES);
    assign m_ok    = (32'(cmd_reg.mon_id) < NUM_MONITORS) && mon_use_reg[midx];

    always_comb begin
        if (!in_use_reg[pidx]) begin
            link_st = ST_ARG;
        end else if (queued_reg[pidx]) begin
            link_st = ST_STATE;
        end else begin
            link_st = ST_OK;
        end
    end

    // lowest free process slot and monitor
    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        mfree_found = 1'b0;
        mfree_idx   = '0;
        for (int i = NUM_PROCESSES - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
        for (int j = NUM_MONITORS - 1; j >= 0; j--) begin
            if (!mon_use_reg[j]) begin
                mfree_found = 1'b1;
                mfree_idx   = MW'(j);
            end
        end
    end

    // command checks
    always_comb begin
        exec_state  = S_DONE;
        exec_status = ST_OK;
        case (cmd_reg.op)
            OP_CREATE: begin
                exec_status = free_found ? ST_OK : ST_NOSLOT;
            end
            OP_READY, OP_TERMINATE, OP_SLEEP: begin
                if (!p_ok) begin
                    exec_status = ST_ARG;
                end else if (link_st != ST_OK) begin
                    exec_status = link_st;
                end else if (cmd_reg.op != OP_TERMINATE) begin
                    exec_state = S_PUT_INIT;
                end
            end
            OP_POP: begin
                exec_state = S_TAKE;
            end
            OP_ROUSE: begin
                exec_state = S_ROUSE;
            end
            OP_MON_CREATE: begin
                exec_status = mfree_found ? ST_OK : ST_NOSLOT;
            end
            OP_ENTER: begin
                if (!m_ok || !p_ok) begin
                    exec_status = ST_ARG;
                end else if (mon_busy_reg[midx]) begin
                    if (link_st != ST_OK) begin
                        exec_status = link_st;
                    end else begin
                        exec_status = ST_BLOCKED;
                        exec_state  = S_PUT_INIT;
                    end
                end
            end
            OP_EXIT, OP_WAIT, OP_NOTIFY: begin
                if (!m_ok || !p_ok) begin
                    exec_status = ST_ARG;
                end else if (owner_reg[midx] != pid_ext) begin
                    exec_status = ST_STATE;
                end else if (cmd_reg.op == OP_WAIT) begin
                    if (link_st != ST_OK) begin
                        exec_status = link_st;
                    end else begin
                        exec_status = ST_BLOCKED;
                        exec_state  = S_PUT_INIT;
                    end
                end else begin
                    exec_state = S_TAKE;
                end
            end
            default: begin
                exec_status = ST_ARG;
            end
        endcase
    end

    assign sleep_h = head_reg[QSLEEP];
    assign take_h  = head_reg[take_q_reg];

    // single read port on the key tables
    always_comb begin
        case (state_reg)
            S_WALK:  rd_idx = t_reg;
            S_TAKE:  rd_idx = take_h;
            S_ROUSE: rd_idx = sleep_h;
            default: rd_idx = pid_ext;
        endcase
    end
    assign prio_rd = prio_reg[PW'(rd_idx)];
    assign wake_rd = wake_reg[PW'(rd_idx)];

    always_comb begin
        if (state_reg == S_ROUSE) begin
            cmp_a = cmd_reg.time_value;
            cmp_b = wake_rd;
        end else begin
            cmp_a = key_reg;
            cmp_b = by_wake_reg ? wake_rd : 64'(prio_rd);
        end
    end

    tsm_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    // insert goes behind every entry whose key is not greater
    assign walk_stop = (t_reg == NIL) || (32'(guard_reg) >= NUM_PROCESSES) || cmp_lt;
    assign rouse_go  = (32'(moved_reg) < NUM_PROCESSES) && (sleep_h != NIL) && !cmp_lt;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_EXEC;
            S_EXEC:     state_next = exec_state;
            S_PUT_INIT: state_next = S_WALK;
            S_WALK:     if (walk_stop) state_next = S_LINK;
            S_LINK: begin
                case (post_reg)
                    POST_HAND:  state_next = S_TAKE;
                    POST_ROUSE: state_next = S_ROUSE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_TAKE: begin
                if (tk_reg == TK_POP || take_h == NIL) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_PUT_INIT;
                end
            end
            S_ROUSE:    state_next = rouse_go ? S_PUT_INIT : S_DONE;
            S_DONE:     if (res_take) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and table updates
    always_comb begin
        cmd_next      = cmd_reg;
        in_use_next   = in_use_reg;
        queued_next   = queued_reg;
        prio_next     = prio_reg;
        wake_next     = wake_reg;
        link_next     = link_reg;
        head_next     = head_reg;
        mon_use_next  = mon_use_reg;
        mon_busy_next = mon_busy_reg;
        owner_next    = owner_reg;
        q_next        = q_reg;
        take_q_next   = take_q_reg;
        node_next     = node_reg;
        t_next        = t_reg;
        after_next    = after_reg;
        guard_next    = guard_reg;
        moved_next    = moved_reg;
        key_next      = key_reg;
        by_wake_next  = by_wake_reg;
        post_next     = post_reg;
        tk_next       = tk_reg;
        status_next   = status_reg;
        pid_out_next  = pid_out_reg;
        mon_out_next  = mon_out_reg;

        case (state_reg)
            S_IDLE: begin
                if (start) cmd_next = cmd;
            end
            S_EXEC: begin
                status_next  = exec_status;
                pid_out_next = '0;
                mon_out_next = '0;
                moved_next   = '0;
                post_next    = POST_DONE;
                by_wake_next = 1'b0;
                node_next    = pid_ext;
                key_next     = 64'(prio_rd);
                case (cmd_reg.op)
                    OP_CREATE: begin
                        if (free_found) begin
                            in_use_next[free_idx] = 1'b1;
                            queued_next[free_idx] = 1'b0;
                            prio_next[free_idx]   = PRIORITY_BITS'(cmd_reg.priority_req);
                            link_next[free_idx]   = NIL;
                            pid_out_next          = free_idx;
                        end
                    end
                    OP_READY: begin
                        q_next = QREADY;
                    end
                    OP_SLEEP: begin
                        q_next       = QSLEEP;
                        key_next     = cmd_reg.time_value;
                        by_wake_next = 1'b1;
                        if (exec_state == S_PUT_INIT) wake_next[pidx] = cmd_reg.time_value;
                    end
                    OP_POP: begin
                        take_q_next = QREADY;
                        tk_next     = TK_POP;
                    end
                    OP_MON_CREATE: begin
                        if (mfree_found) begin
                            mon_use_next[mfree_idx]  = 1'b1;
                            mon_busy_next[mfree_idx] = 1'b0;
                            owner_next[mfree_idx]    = NIL;
                            head_next[QW'(2 + int'(mfree_idx))]                = NIL;
                            head_next[QW'(2 + NUM_MONITORS + int'(mfree_idx))] = NIL;
                            mon_out_next = mfree_idx;
                        end
                    end
                    OP_ENTER: begin
                        q_next = qe;
                        if (m_ok && p_ok && !mon_busy_reg[midx]) begin
                            mon_busy_next[midx] = 1'b1;
                            owner_next[midx]    = pid_ext;
                        end
                    end
                    OP_EXIT: begin
                        take_q_next = qe;
                        tk_next     = TK_HAND;
                    end
                    OP_WAIT: begin
                        q_next    = qc;
                        post_next = POST_HAND;
                    end
                    OP_NOTIFY: begin
                        take_q_next = qc;
                        tk_next     = TK_NOTIFY;
                    end
                    default: ;
                endcase
            end
            S_PUT_INIT: begin
                t_next     = head_reg[q_reg];
                after_next = NIL;
                guard_next = '0;
            end
            S_WALK: begin
                if (!walk_stop) begin
                    after_next = t_reg;
                    t_next     = link_reg[PW'(t_reg)];
                    guard_next = guard_reg + 1'b1;
                end
            end
            S_LINK: begin
                link_next[PW'(node_reg)] = t_reg;
                if (after_reg == NIL) begin
                    head_next[q_reg] = node_reg;
                end else begin
                    link_next[PW'(after_reg)] = node_reg;
                end
                queued_next[PW'(node_reg)] = 1'b1;
                if (post_reg == POST_HAND) begin
                    take_q_next = qe;
                    tk_next     = TK_HAND;
                end
            end
            S_TAKE: begin
                if (take_h != NIL) begin
                    head_next[take_q_reg]    = link_reg[PW'(take_h)];
                    link_next[PW'(take_h)]   = NIL;
                    queued_next[PW'(take_h)] = 1'b0;
                end
                node_next    = take_h;
                key_next     = 64'(prio_rd);
                by_wake_next = 1'b0;
                post_next    = POST_DONE;
                case (tk_reg)
                    TK_POP: begin
                        if (take_h == NIL) begin
                            status_next = ST_EMPTY;
                        end else begin
                            pid_out_next = PW'(take_h);
                        end
                    end
                    TK_HAND: begin
                        owner_next[midx] = take_h;
                        q_next           = QREADY;
                        if (take_h == NIL) mon_busy_next[midx] = 1'b0;
                    end
                    default: begin
                        q_next = qe;
                    end
                endcase
            end
            S_ROUSE: begin
                if (rouse_go) begin
                    head_next[QSLEEP]         = link_reg[PW'(sleep_h)];
                    link_next[PW'(sleep_h)]   = NIL;
                    queued_next[PW'(sleep_h)] = 1'b0;
                    moved_next   = moved_reg + 1'b1;
                    q_next       = QREADY;
                    node_next    = sleep_h;
                    key_next     = 64'(prio_rd);
                    by_wake_next = 1'b0;
                    post_next    = POST_ROUSE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            in_use_reg   <= '0;
            queued_reg   <= '0;
            mon_use_reg  <= '0;
            mon_busy_reg <= '0;
            for (int i = 0; i < NUM_PROCESSES; i++) link_reg[i] <= NIL;
            for (int i = 0; i < NQ; i++) head_reg[i] <= NIL;
            for (int i = 0; i < NUM_MONITORS; i++) owner_reg[i] <= NIL;
        end else begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            queued_reg   <= queued_next;
            mon_use_reg  <= mon_use_next;
            mon_busy_reg <= mon_busy_next;
            link_reg     <= link_next;
            head_reg     <= head_next;
            owner_reg    <= owner_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        prio_reg    <= prio_next;
        wake_reg    <= wake_next;
        q_reg       <= q_next;
        take_q_reg  <= take_q_next;
        node_reg    <= node_next;
        t_reg       <= t_next;
        after_reg   <= after_next;
        guard_reg   <= guard_next;
        moved_reg   <= moved_next;
        key_reg     <= key_next;
        by_wake_reg <= by_wake_next;
        post_reg    <= post_next;
        tk_reg      <= tk_next;
        status_reg  <= status_next;
        pid_out_reg <= pid_out_next;
        mon_out_reg <= mon_out_next;
    end

    assign idle            = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.pid_out     = 3'(pid_out_reg);
    assign res.mon_out     = 2'(mon_out_reg);
    assign res.moved_count = 4'(moved_reg);

endmodule

FILE: sv/task_scheduler_with_monitors_top.sv
// ----------------------------------------------------------------------------
// task_scheduler_with_monitors_top
// Command-driven scheduler: process table, ordered queues and monitor locks.
// ----------------------------------------------------------------------------
// A command with no queue work passes from the command register through S_EXEC
// and S_DONE into the output register, once that register is free to take it.
// An ordered insert adds S_PUT_INIT, a link walk over up to NUM_PROCESSES entries
// and S_LINK; a rouse repeats removal + insert per moved process.
// Throughput: one command at a time; s_ready is high only while the sequencer
// is idle. A finished result waits in the output register.
// Reset (aresetn low, synchronous): tables empty, all queue links null.
module task_scheduler_with_monitors_top #(
    parameter int NUM_PROCESSES = 8,
    parameter int NUM_MONITORS  = 4,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [2:0]  s_pid,
    input  logic [1:0]  s_mon_id,
    input  logic [7:0]  s_priority_req,
    input  logic [63:0] s_time_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_pid_out,
    output logic [1:0]  m_mon_out,
    output logic [3:0]  m_moved_count
);
    import tsm_pkg::*;

    cmd_t    cmd;
    result_t res, res_reg, res_next;
    logic    idle, res_valid, res_take, start;
    logic    m_valid_reg, m_valid_next;

    assign cmd.op           = s_op;
    assign cmd.pid          = s_pid;
    assign cmd.mon_id       = s_mon_id;
    assign cmd.priority_req = s_priority_req;
    assign cmd.time_value   = s_time_value;

    assign s_ready  = idle;
    assign start    = s_valid && idle;
    assign res_take = !m_valid_reg || m_ready;

    tsm_engine #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_MONITORS  (NUM_MONITORS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cmd       (cmd),
        .idle      (idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (res_valid && res_take) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = res_reg.status;
    assign m_pid_out     = res_reg.pid_out;
    assign m_mon_out     = res_reg.mon_out;
    assign m_moved_count = res_reg.moved_count;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer still idle after a transaction was accepted");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_take) |=> m_valid)
        else $error("finished result not loaded into output register");

    a_status_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_EMPTY))
        else $error("status code out of range");

endmodule
